// ----- rtl/core/sse_pkg.sv -----
// Shared types, constants and the quarter-wave sine table for the sweep excitation unit.
package sse_pkg;

   localparam int unsigned SINE_TABLE_DEPTH = 256;
   localparam int unsigned SINE_INDEX_BITS  = $clog2(SINE_TABLE_DEPTH);
   localparam int unsigned SINE_ADDR_BITS   = SINE_INDEX_BITS + 1;
   localparam int unsigned CLIP_LIMIT       = 16384;
   localparam int unsigned ACTION_SCALE     = 256;
   localparam int          JOINT_OFFSET     = 0;
   localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;

   localparam logic [2:0] CSR_WAVEFORM_MODE   = 3'd0;
   localparam logic [2:0] CSR_AMPLITUDE       = 3'd1;
   localparam logic [2:0] CSR_SWEEP_MIN_FREQ  = 3'd2;
   localparam logic [2:0] CSR_SWEEP_FREQ_STEP = 3'd3;
   localparam logic [2:0] CSR_SWEEP_MAX_FREQ  = 3'd4;
   localparam logic [2:0] CSR_SWEEP_STEP_TIME = 3'd5;
   localparam logic [2:0] CSR_CONSTANT_FREQ   = 3'd6;

   typedef logic [15:0] sine_lut_type [0:SINE_TABLE_DEPTH];

   typedef struct packed {
      logic load_req;
      logic div_step;
      logic mul_freq;
      logic cmp_freq;
      logic mul_phase;
      logic wave;
      logic fin;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic sweep;
      logic estop;
   } ctl_sts_type;

   function automatic logic [15:0] sine_q15(input logic [63:0] x);
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] q;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         case (n)
            1: term = term / 6;
            2: term = term / 20;
            3: term = term / 42;
            4: term = term / 72;
            5: term = term / 110;
            6: term = term / 156;
            default: term = term / 210;
         endcase
         if (n % 2 == 1) sum = sum - signed'(term);
         else sum = sum + signed'(term);
      end
      if (sum < 0) sum = 0;
      q = (unsigned'(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) q = 64'd32767;
      return q[15:0];
   endfunction

   function automatic sine_lut_type build_sine_lut();
      sine_lut_type lut;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         lut[k] = sine_q15(HALF_PI_Q30 * 64'(k) / SINE_TABLE_DEPTH);
      end
      return lut;
   endfunction

endpackage

// ----- rtl/core/sse_ctrl.sv -----
// Sequencing state machine for the sweep excitation unit.
module sse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  sse_pkg::ctl_sts_type sts,
   output sse_pkg::ctl_cmd_type cmd
);
   import sse_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_DIV, ST_MUL_F, ST_CMP, ST_PHASE, ST_WAVE, ST_FIN, ST_WRITE
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd           = '0;
      cmd.load_req  = (state_ff == ST_IDLE) && req_valid;
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.mul_freq  = (state_ff == ST_MUL_F);
      cmd.cmp_freq  = (state_ff == ST_CMP);
      cmd.mul_phase = (state_ff == ST_PHASE);
      cmd.wave      = (state_ff == ST_WAVE);
      cmd.fin       = (state_ff == ST_FIN);
      cmd.load_rsp  = (state_ff == ST_WRITE) && slot_free;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            cnt_in = '0;
            if (sts.estop) state_in = ST_WRITE;
            else if (sts.sweep) state_in = ST_DIV;
            else state_in = ST_PHASE;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = ST_MUL_F;
         end
         ST_MUL_F: state_in = ST_CMP;
         ST_CMP:   state_in = ST_PHASE;
         ST_PHASE: state_in = ST_WAVE;
         ST_WAVE:  state_in = ST_FIN;
         ST_FIN:   state_in = ST_WRITE;
         ST_WRITE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/sse_datapath.sv -----
// Configuration registers, divider, multipliers, sine lookup and result register.
module sse_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [23:0]          csr_data,
   input  logic [31:0]          req_elapsed_time,
   input  logic                 req_estop,
   input  sse_pkg::ctl_cmd_type cmd,
   output sse_pkg::ctl_sts_type sts,
   output logic signed [15:0]   rsp_command,
   output logic [15:0]          rsp_frequency,
   output logic [23:0]          rsp_phase,
   output logic                 rsp_sweep_done
);
   import sse_pkg::*;

   localparam sine_lut_type SINE_LUT = build_sine_lut();

   logic [1:0]  mode_ff;
   logic [14:0] amp_ff;
   logic [15:0] min_ff, step_ff, max_ff, cf_ff;
   logic [23:0] dwell_ff;

   logic [31:0] t_ff, qd_ff, qd_in;
   logic        estop_ff;
   logic [23:0] rem_ff, rem_in, dwell;
   logic [24:0] rem_sh, rem_diff;
   logic        rem_ge;

   logic [47:0] prod_ff;
   logic [48:0] fsum;
   logic        fdone;
   logic [15:0] freq_ff, ofreq_ff;
   logic        done_ff, odone_ff;

   logic [23:0] acc_ff, mul_a, phase_new;
   logic [31:0] prev_ff, delta;
   logic [15:0] mul_b;
   logic [39:0] mul_p;

   logic [1:0]                quad;
   logic [SINE_INDEX_BITS-1:0] tab_i;
   logic [SINE_ADDR_BITS-1:0]  tab_addr;
   logic [15:0]               tab_s;
   logic [30:0]               amp_p;
   logic                      neg_ff, neg_in;
   logic [15:0]               mag_ff, mag_in;

   logic [15:0]        magc;
   logic [32:0]        scl_p;
   logic [24:0]        scl_m;
   logic signed [26:0] sval, cmd_w;
   logic signed [15:0] cmd_ff, cmd_sat;

   assign sts.sweep = mode_ff[0];
   assign sts.estop = estop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         amp_ff   <= '0;
         min_ff   <= '0;
         step_ff  <= '0;
         max_ff   <= '0;
         dwell_ff <= 24'd65536;
         cf_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WAVEFORM_MODE:   mode_ff  <= csr_data[1:0];
            CSR_AMPLITUDE:       amp_ff   <= csr_data[14:0];
            CSR_SWEEP_MIN_FREQ:  min_ff   <= csr_data[15:0];
            CSR_SWEEP_FREQ_STEP: step_ff  <= csr_data[15:0];
            CSR_SWEEP_MAX_FREQ:  max_ff   <= csr_data[15:0];
            CSR_SWEEP_STEP_TIME: dwell_ff <= csr_data;
            CSR_CONSTANT_FREQ:   cf_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Restoring divider, one quotient bit per cycle.
   assign dwell    = (dwell_ff == '0) ? 24'd1 : dwell_ff;
   assign rem_sh   = {rem_ff, qd_ff[31]};
   assign rem_ge   = rem_sh >= {1'b0, dwell};
   assign rem_diff = rem_sh - {1'b0, dwell};
   assign rem_in   = rem_ge ? rem_diff[23:0] : rem_sh[23:0];
   assign qd_in    = {qd_ff[30:0], rem_ge};

   assign fsum  = 49'(min_ff) + 49'(prod_ff);
   assign fdone = fsum > 49'(max_ff);

   assign delta     = t_ff - prev_ff;
   assign mul_a     = mode_ff[0] ? t_ff[23:0] : delta[23:0];
   assign mul_b     = mode_ff[0] ? freq_ff : cf_ff;
   assign mul_p     = mul_a * mul_b;
   assign phase_new = mul_p[23:0] + (mode_ff[0] ? 24'd0 : acc_ff);

   assign quad     = acc_ff[23:22];
   assign tab_i    = acc_ff[21 -: SINE_INDEX_BITS];
   assign tab_addr = quad[0] ? SINE_ADDR_BITS'(SINE_TABLE_DEPTH) - {1'b0, tab_i}
                             : {1'b0, tab_i};
   assign tab_s    = SINE_LUT[tab_addr];
   assign amp_p    = tab_s[14:0] * amp_ff + 31'd16384;

   always_comb begin
      if (mode_ff[1]) begin
         neg_in = acc_ff > 24'h800000;
         mag_in = {1'b0, amp_ff};
      end else begin
         neg_in = quad[1];
         mag_in = amp_p[30:15];
      end
   end

   assign magc  = (mag_ff > 16'(CLIP_LIMIT)) ? 16'(CLIP_LIMIT) : mag_ff;
   assign scl_p = 33'(magc) * 33'(ACTION_SCALE) + 33'd128;
   assign scl_m = scl_p[32:8];
   assign sval  = neg_ff ? -signed'({2'b00, scl_m}) : signed'({2'b00, scl_m});
   assign cmd_w = sval + 27'(JOINT_OFFSET);

   always_comb begin
      if (cmd_w > 27'sd32767) cmd_sat = 16'sh7FFF;
      else if (cmd_w < -27'sd32768) cmd_sat = -16'sh8000;
      else cmd_sat = cmd_w[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         prev_ff <= '0;
      end else if (cmd.mul_phase) begin
         acc_ff  <= phase_new;
         prev_ff <= t_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         t_ff     <= req_elapsed_time;
         estop_ff <= req_estop;
         qd_ff    <= req_elapsed_time;
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         qd_ff  <= qd_in;
         rem_ff <= rem_in;
      end
      if (cmd.mul_freq) prod_ff <= qd_ff * step_ff;
      if (cmd.cmp_freq) begin
         freq_ff <= fdone ? 16'd0 : fsum[15:0];
         done_ff <= fdone;
      end
      if (cmd.mul_phase) begin
         ofreq_ff <= mode_ff[0] ? freq_ff : cf_ff;
         odone_ff <= mode_ff[0] && done_ff;
      end
      if (cmd.wave) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
      if (cmd.fin) cmd_ff <= cmd_sat;
      if (cmd.load_rsp) begin
         rsp_phase <= acc_ff;
         if (estop_ff) begin
            rsp_command    <= '0;
            rsp_frequency  <= '0;
            rsp_sweep_done <= 1'b0;
         end else begin
            rsp_command    <= cmd_ff;
            rsp_frequency  <= ofreq_ff;
            rsp_sweep_done <= odone_ff;
         end
      end
   end

endmodule

// ----- rtl/core/stepped_sine_sweep_excitation_unit.sv -----
// Top level of the stepped sine sweep excitation unit.
// Each request beat carries elapsed time and an emergency-stop bit and yields one
// response beat. A sweep-mode beat runs the 32-step restoring divider that finds the
// sweep step (one quotient bit per cycle) ahead of the frequency and phase stages; a
// constant-mode beat starts at the phase stage and an emergency-stop beat goes to
// the response write. Configuration writes are always ready. One beat is processed
// at a time; a finished result waits in the response register as the next is taken.
module stepped_sine_sweep_excitation_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_elapsed_time,
   input  logic               req_estop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_command,
   output logic [15:0]        rsp_frequency,
   output logic [23:0]        rsp_phase,
   output logic               rsp_sweep_done
);
   import sse_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   assign csr_ready = 1'b1;

   sse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sse_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_elapsed_time (req_elapsed_time),
      .req_estop        (req_estop),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_command      (rsp_command),
      .rsp_frequency    (rsp_frequency),
      .rsp_phase        (rsp_phase),
      .rsp_sweep_done   (rsp_sweep_done)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while not busy afterwards");

   a_done_zero_freq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sweep_done) |-> (rsp_frequency == 16'd0))
      else $error("sweep done with non-zero frequency");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_single_cmd_stage: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.div_step, cmd.mul_freq, cmd.cmp_freq, cmd.mul_phase, cmd.wave,
                cmd.fin, cmd.load_rsp}))
      else $error("more than one datapath stage commanded");

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the stepped sine sweep excitation unit, with its own predictor.
module tb;
   import sse_pkg::*;

   typedef enum logic [1:0] {ROW_CSR, ROW_TICK, ROW_CHECKED} row_kind_type;

   typedef struct packed {
      logic signed [15:0] command;
      logic [15:0]        frequency;
      logic [23:0]        phase;
      logic               sweep_done;
   } excitation_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [2:0]         index;
      logic [31:0]        value;
      logic               estop;
      excitation_type     result;
   } row_type;

   localparam int LIMIT_CYCLES = 2000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = CSR_WAVEFORM_MODE;
   logic [23:0]        csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [31:0]        req_elapsed_time = '0;
   logic               req_estop = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_command;
   logic [15:0]        rsp_frequency;
   logic [23:0]        rsp_phase;
   logic               rsp_sweep_done;

   logic [15:0]    quarter_wave [0:SINE_TABLE_DEPTH];
   logic [1:0]     mode_q;
   logic [14:0]    amplitude_q;
   logic [15:0]    min_freq_q, freq_step_q, max_freq_q, const_freq_q;
   logic [23:0]    step_time_q;
   logic [23:0]    phase_acc;
   logic [31:0]    last_time;
   excitation_type pending_results [$];
   int             mismatches = 0;
   int             cycles = 0;
   bit             quiet = 1'b0;
   bit             hold_request = 1'b0;
   row_type        rows [$];

   always #10 clock = ~clock;

   stepped_sine_sweep_excitation_unit i_dut (.*);

   function automatic logic [15:0] sine_sample(input logic [63:0] x);
      logic [63:0]        power;
      logic signed [63:0] acc;
      logic [63:0]        rounded;
      power = x;
      acc   = signed'(x);
      for (int n = 1; n <= 7; n++) begin
         power = (((power * x) >> 30) * x) >> 30;
         power = power / (64'(2 * n) * 64'(2 * n + 1));
         acc   = (n % 2 == 1) ? acc - signed'(power) : acc + signed'(power);
      end
      if (acc < 0) acc = 0;
      rounded = (unsigned'(acc) + 64'd16384) >> 15;
      return (rounded > 64'd32767) ? 16'd32767 : rounded[15:0];
   endfunction

   function automatic void apply_register(input logic [2:0] index, input logic [31:0] value);
      case (index)
         CSR_WAVEFORM_MODE:   mode_q       = value[1:0];
         CSR_AMPLITUDE:       amplitude_q  = value[14:0];
         CSR_SWEEP_MIN_FREQ:  min_freq_q   = value[15:0];
         CSR_SWEEP_FREQ_STEP: freq_step_q  = value[15:0];
         CSR_SWEEP_MAX_FREQ:  max_freq_q   = value[15:0];
         CSR_SWEEP_STEP_TIME: step_time_q  = value[23:0];
         CSR_CONSTANT_FREQ:   const_freq_q = value[15:0];
         default: ;
      endcase
   endfunction

   function automatic excitation_type predict_excitation(input logic [31:0] t, input logic estop);
      excitation_type     r;
      logic [63:0]        dwell, freq, lowbits, idx, mag;
      logic [31:0]        delta;
      logic signed [63:0] pos, prod, cmd, clip;
      logic [15:0]        sample;
      r = '0;
      clip = signed'(64'(CLIP_LIMIT));
      if (estop) begin
         r.phase = phase_acc;
         return r;
      end
      if (mode_q[0]) begin
         dwell = (step_time_q == 0) ? 64'd1 : 64'(step_time_q);
         freq  = 64'(min_freq_q) + (64'(t) / dwell) * 64'(freq_step_q);
         if (freq > 64'(max_freq_q)) begin
            freq = 0;
            r.sweep_done = 1'b1;
         end
         phase_acc = 24'(64'(t) * freq);
      end else begin
         delta     = t - last_time;
         freq      = 64'(const_freq_q);
         phase_acc = 24'(64'(phase_acc) + 64'(delta) * freq);
      end
      last_time = t;
      if (mode_q[1]) begin
         pos = (phase_acc <= 24'h800000) ? 64'(amplitude_q) : -64'(amplitude_q);
      end else begin
         lowbits = 64'(phase_acc[21:0]);
         idx     = (lowbits * SINE_TABLE_DEPTH) >> 22;
         sample  = phase_acc[22] ? quarter_wave[SINE_TABLE_DEPTH - idx] : quarter_wave[idx];
         mag     = (64'(sample) * 64'(amplitude_q) + 64'd16384) >> 15;
         pos     = phase_acc[23] ? -signed'(mag) : signed'(mag);
      end
      if (pos > clip) pos = clip;
      if (pos < -clip) pos = -clip;
      prod = pos * ACTION_SCALE;
      cmd  = ((prod < 0 ? -prod : prod) + 128) >>> 8;
      if (prod < 0) cmd = -cmd;
      cmd = cmd + JOINT_OFFSET;
      if (cmd > 32767) cmd = 32767;
      if (cmd < -32768) cmd = -32768;
      r.command   = cmd[15:0];
      r.frequency = freq[15:0];
      r.sweep_done = r.sweep_done;
      r.phase     = phase_acc;
      return r;
   endfunction

   task automatic wait_idle();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value[23:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(index, value);
   endtask

   task automatic send_tick(input logic [31:0] t, input logic estop, input bit typed,
                            input excitation_type typed_result);
      excitation_type predicted;
      req_valid        <= 1'b1;
      req_elapsed_time <= t;
      req_estop        <= estop;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_excitation(t, estop);
      pending_results.push_back(typed ? typed_result : predicted);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_register(input logic [2:0] index);
      int choice;
      choice = $urandom_range(0, 5);
      case (index)
         CSR_WAVEFORM_MODE: return $urandom_range(0, 3);
         CSR_AMPLITUDE:
            return choice == 0 ? 0 : choice == 1 ? 32767 : $urandom_range(0, 32767);
         CSR_SWEEP_STEP_TIME:
            return choice == 0 ? 1 : choice == 1 ? 24'hFFFFFF : choice == 2 ? 0 :
                   $urandom_range(1, 4000);
         default:
            return choice == 0 ? 0 : choice == 1 ? 65535 : $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic void add_row(input row_kind_type kind, input logic [2:0] index,
                                   input logic [31:0] value, input logic estop,
                                   input excitation_type result);
      row_type row;
      row.kind   = kind;
      row.index  = index;
      row.value  = value;
      row.estop  = estop;
      row.result = result;
      rows.push_back(row);
   endfunction

   initial begin
      logic [31:0]    t, span;
      logic [63:0]    steps;
      int             items, phase_items;
      excitation_type typed;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         quarter_wave[k] = sine_sample(HALF_PI_Q30 * 64'(k) / SINE_TABLE_DEPTH);
      end
      mode_q = 0; amplitude_q = 0; min_freq_q = 0; freq_step_q = 0;
      max_freq_q = 0; step_time_q = 24'd65536; const_freq_q = 0;
      phase_acc = 0; last_time = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_row(ROW_CHECKED, 0, 32'd0, 1'b0, '0);
      add_row(ROW_CHECKED, 0, 32'hFFFFFFFF, 1'b0, '0);
      add_row(ROW_CHECKED, 0, 32'd5, 1'b1, '0);
      add_row(ROW_CSR, CSR_WAVEFORM_MODE, 1, 0, '0);
      add_row(ROW_CSR, CSR_AMPLITUDE, 32767, 0, '0);
      add_row(ROW_CSR, CSR_SWEEP_MIN_FREQ, 0, 0, '0);
      add_row(ROW_CSR, CSR_SWEEP_FREQ_STEP, 65535, 0, '0);
      add_row(ROW_CSR, CSR_SWEEP_MAX_FREQ, 65535, 0, '0);
      add_row(ROW_CSR, CSR_SWEEP_STEP_TIME, 1, 0, '0);
      add_row(ROW_TICK, 0, 32'd0, 1'b0, '0);
      add_row(ROW_TICK, 0, 32'd1, 1'b0, '0);
      typed = '0;
      typed.sweep_done = 1'b1;
      add_row(ROW_CHECKED, 0, 32'd2, 1'b0, typed);
      add_row(ROW_TICK, 0, 32'hFFFFFFFF, 1'b1, '0);
      add_row(ROW_CSR, CSR_SWEEP_STEP_TIME, 0, 0, '0);
      add_row(ROW_TICK, 0, 32'd1, 1'b0, '0);
      add_row(ROW_CSR, CSR_WAVEFORM_MODE, 3, 0, '0);
      add_row(ROW_CSR, CSR_SWEEP_STEP_TIME, 24'hFFFFFF, 0, '0);
      add_row(ROW_CSR, CSR_SWEEP_MIN_FREQ, 65535, 0, '0);
      add_row(ROW_TICK, 0, 32'd128, 1'b0, '0);
      add_row(ROW_TICK, 0, 32'd256, 1'b0, '0);
      add_row(ROW_CSR, CSR_WAVEFORM_MODE, 0, 0, '0);
      add_row(ROW_CSR, CSR_CONSTANT_FREQ, 65535, 0, '0);
      add_row(ROW_TICK, 0, 32'd100, 1'b0, '0);
      add_row(ROW_TICK, 0, 32'd50, 1'b0, '0);
      add_row(ROW_TICK, 0, 32'hFFFFFFFF, 1'b0, '0);

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            req_valid <= 1'b0;
            wait_idle();
            write_register(rows[i].index, rows[i].value);
            csr_valid <= 1'b0;
         end else begin
            send_tick(rows[i].value, rows[i].estop, rows[i].kind == ROW_CHECKED,
                      rows[i].result);
         end
      end

      items = 0;
      for (int p = 0; items < 1700; p++) begin
         req_valid <= 1'b0;
         wait_idle();
         for (int r = 0; r < 7; r++) write_register(3'(r), pick_register(3'(r)));
         csr_valid <= 1'b0;
         quiet        = (items >= 1500);
         hold_request = (p == 3);
         phase_items  = $urandom_range(60, 140);
         t = $urandom();
         for (int n = 0; n < phase_items; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               t = $urandom();
            end else if (mode_q[0]) begin
               span  = (step_time_q == 0) ? 32'd1 : 32'(step_time_q);
               steps = (freq_step_q == 0) ? 64'd3 :
                       64'((max_freq_q - min_freq_q) / freq_step_q) + 2;
               if (max_freq_q < min_freq_q) steps = 2;
               t = 32'($urandom_range(0, 32'(steps)) * 64'(span) + $urandom_range(0, span - 1));
            end else begin
               t = t + $urandom_range(0, 2000);
            end
            send_tick(t, $urandom_range(0, 15) == 0, 1'b0, '0);
            items++;
         end
      end
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      int hold_left, burst_left;
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end else begin
         if (hold_request && hold_left == 0) begin
            hold_request = 1'b0;
            hold_left    = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 13);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      excitation_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_command, rsp_frequency, rsp_phase, rsp_sweep_done};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %p", got);
         end else begin
            want = pending_results.pop_front();
            if (want != got) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

endmodule

// ----- stepped_sine_sweep_excitation_unit.f -----
rtl/core/sse_pkg.sv
rtl/core/sse_ctrl.sv
rtl/core/sse_datapath.sv
rtl/core/stepped_sine_sweep_excitation_unit.sv
bench/tb.sv
